[design/xcpd_pkg.sv]
// ============================================================================
// Packet deframer package
// Shared types, codes and helpers for the checked packet deframer.
// ============================================================================
package xcpd_pkg;

    typedef enum logic [1:0] {
        OP_DATA    = 2'd0,
        OP_START   = 2'd1,
        OP_CONNECT = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_TYPE    = 11'b000_0000_0010,
        PH_SIZE_LO = 11'b000_0000_0100,
        PH_SIZE_HI = 11'b000_0000_1000,
        PH_SEQ_LO  = 11'b000_0001_0000,
        PH_SEQ_HI  = 11'b000_0010_0000,
        PH_PLEN    = 11'b000_0100_0000,
        PH_PAYLOAD = 11'b000_1000_0000,
        PH_PCODE   = 11'b001_0000_0000,
        PH_PVAL    = 11'b010_0000_0000,
        PH_CHECK   = 11'b100_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        UP_CLOSED  = 2'd0,
        UP_OPENING = 2'd1,
        UP_OPENED  = 2'd2,
        UP_CLOSING = 2'd3
    } t_uplink;

    localparam logic [2:0] PK_END      = 3'd0;
    localparam logic [2:0] PK_OPEN     = 3'd1;
    localparam logic [2:0] PK_CLOSE    = 3'd2;
    localparam logic [2:0] PK_ACK      = 3'd3;
    localparam logic [2:0] PK_BEGIN    = 3'd4;
    localparam logic [2:0] PK_CONTINUE = 3'd5;
    localparam logic [2:0] PK_REQ_UP   = 3'd6;
    localparam logic [2:0] PK_SET_PARM = 3'd7;

    localparam logic [3:0] EV_OPEN        = 4'd0;
    localparam logic [3:0] EV_UP_OPENED   = 4'd1;
    localparam logic [3:0] EV_UP_CLOSED   = 4'd2;
    localparam logic [3:0] EV_DATA_ACK    = 4'd3;
    localparam logic [3:0] EV_MSG_HEADER  = 4'd4;
    localparam logic [3:0] EV_PAYLOAD     = 4'd5;
    localparam logic [3:0] EV_MSG_DONE    = 4'd6;
    localparam logic [3:0] EV_FETCH_LEN   = 4'd7;
    localparam logic [3:0] EV_CHECK_ERR   = 4'd8;
    localparam logic [3:0] EV_UNSUPPORTED = 4'd9;
    localparam logic [3:0] EV_TRUNCATED   = 4'd10;
    localparam logic [3:0] EV_CONNECT     = 4'd11;

    localparam logic [7:0] FETCH_CODE_RESET = 8'd1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] seq;
        logic [15:0] size;
        logic        begins;
        logic [7:0]  value;
        logic        refused;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_ev_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic t_event make_event(input logic [3:0] kind, input logic [15:0] seq,
                                          input logic [15:0] size, input logic begins,
                                          input logic [7:0] value, input logic refused);
        t_event e;
        e.kind    = kind;
        e.seq     = seq;
        e.size    = size;
        e.begins  = begins;
        e.value   = value;
        e.refused = refused;
        return e;
    endfunction

endpackage

[design/xcpd_front.sv]
// ============================================================================
// Packet deframer front end
// Accepts input beats, runs the packet parser and link state, emits events.
// ============================================================================
module xcpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_accept,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_data_byte,
    output xcpd_pkg::t_ev_push o_push
);
    import xcpd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_xor, n_xor;
    logic [2:0]  r_kind, n_kind;
    logic [15:0] r_field, n_field;
    logic [15:0] r_held, n_held;
    logic [7:0]  r_payload_left, n_payload_left;
    t_uplink     r_uplink, n_uplink;
    logic        r_down_open, n_down_open;
    logic [7:0]  r_fetch_len, n_fetch_len;
    logic [7:0]  r_size_code;

    t_event      msg_ev_base;
    logic        is_begin;
    logic [7:0]  b;

    assign b        = i_data_byte;
    assign is_begin = (r_kind == PK_BEGIN);
    assign msg_ev_base = make_event(EV_MSG_HEADER, r_field, is_begin ? r_held : 16'd0,
                                    is_begin, 8'd0, 1'b0);

    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_xor          = r_xor;
        n_kind         = r_kind;
        n_field        = r_field;
        n_held         = r_held;
        n_payload_left = r_payload_left;
        n_uplink       = r_uplink;
        n_down_open    = r_down_open;
        n_fetch_len    = r_fetch_len;
        o_push         = '0;
        if (i_accept) begin
            case (t_opcode'(i_opcode))
                OP_DATA: begin
                    if (r_phase != PH_IDLE) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (r_phase != PH_TYPE && r_phase != PH_CHECK) begin
                            n_xor = r_xor ^ b;
                        end
                        case (r_phase)
                            PH_TYPE: begin
                                if (b == 8'd0) begin
                                    n_phase      = PH_IDLE;
                                    n_bytes_left = 8'd0;
                                end else if (b[7:3] != 5'd0 || b[2:0] == PK_CLOSE
                                             || b[2:0] == PK_REQ_UP) begin
                                    o_push.valid = 1'b1;
                                    o_push.ev    = make_event(EV_UNSUPPORTED, 16'd0, 16'd0,
                                                              1'b0, 8'd0, 1'b0);
                                    n_phase      = PH_IDLE;
                                    n_bytes_left = 8'd0;
                                end else begin
                                    n_kind         = b[2:0];
                                    n_xor          = b;
                                    n_field        = 16'd0;
                                    n_held         = 16'd0;
                                    n_payload_left = 8'd0;
                                    if (b[2:0] == PK_OPEN) begin
                                        n_phase = PH_CHECK;
                                    end else if (b[2:0] == PK_BEGIN) begin
                                        n_phase = PH_SIZE_LO;
                                    end else if (b[2:0] == PK_SET_PARM) begin
                                        n_phase = PH_PCODE;
                                    end else begin
                                        n_phase = PH_SEQ_LO;
                                    end
                                end
                            end
                            PH_SIZE_LO: begin
                                n_held  = {8'd0, b};
                                n_phase = PH_SIZE_HI;
                            end
                            PH_SIZE_HI: begin
                                n_held  = {b, r_held[7:0]};
                                n_phase = PH_SEQ_LO;
                            end
                            PH_SEQ_LO: begin
                                n_field = {8'd0, b};
                                n_phase = PH_SEQ_HI;
                            end
                            PH_SEQ_HI: begin
                                n_field = {b, r_field[7:0]};
                                n_phase = (r_kind == PK_ACK) ? PH_CHECK : PH_PLEN;
                            end
                            PH_PLEN: begin
                                n_payload_left = b;
                                o_push.valid   = 1'b1;
                                o_push.ev      = msg_ev_base;
                                o_push.ev.value = b;
                                n_phase        = (b != 8'd0) ? PH_PAYLOAD : PH_CHECK;
                            end
                            PH_PAYLOAD: begin
                                o_push.valid    = 1'b1;
                                o_push.ev       = msg_ev_base;
                                o_push.ev.kind  = EV_PAYLOAD;
                                o_push.ev.value = b;
                                n_payload_left  = r_payload_left - 8'd1;
                                if (r_payload_left == 8'd1) begin
                                    n_phase = PH_CHECK;
                                end
                            end
                            PH_PCODE: begin
                                n_phase = (b == r_size_code) ? PH_PVAL : PH_TYPE;
                            end
                            PH_PVAL: begin
                                n_field = {8'd0, b};
                                n_phase = PH_CHECK;
                            end
                            PH_CHECK: begin
                                o_push.valid = 1'b1;
                                if (b != r_xor) begin
                                    o_push.ev    = make_event(EV_CHECK_ERR, 16'd0, 16'd0,
                                                              1'b0, 8'd0, 1'b0);
                                    n_phase      = PH_IDLE;
                                    n_bytes_left = 8'd0;
                                end else begin
                                    n_phase = PH_TYPE;
                                    if (r_kind == PK_OPEN) begin
                                        n_down_open = 1'b1;
                                        o_push.ev   = make_event(EV_OPEN, 16'd0, 16'd0,
                                                                 1'b0, 8'd0, 1'b0);
                                    end else if (r_kind == PK_ACK) begin
                                        o_push.ev = make_event(EV_DATA_ACK, r_field, 16'd0,
                                                               1'b0, 8'd0, 1'b0);
                                        if (r_uplink == UP_OPENING) begin
                                            n_uplink       = UP_OPENED;
                                            o_push.ev.kind = EV_UP_OPENED;
                                        end else if (r_uplink == UP_CLOSING) begin
                                            n_uplink       = UP_CLOSED;
                                            o_push.ev.kind = EV_UP_CLOSED;
                                        end
                                    end else if (r_kind == PK_SET_PARM) begin
                                        n_fetch_len = r_field[7:0];
                                        o_push.ev   = make_event(EV_FETCH_LEN, 16'd0, 16'd0,
                                                                 1'b0, r_field[7:0], 1'b0);
                                    end else begin
                                        o_push.ev      = msg_ev_base;
                                        o_push.ev.kind = EV_MSG_DONE;
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                        // The block ran out: a packet cut short reports truncation.
                        if (n_bytes_left == 8'd0 && n_phase != PH_IDLE) begin
                            if (n_phase != PH_TYPE) begin
                                o_push.valid = 1'b1;
                                o_push.ev    = make_event(EV_TRUNCATED, 16'd0, 16'd0,
                                                          1'b0, 8'd0, 1'b0);
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                end
                OP_START: begin
                    if (r_phase != PH_IDLE && r_phase != PH_TYPE) begin
                        o_push.valid = 1'b1;
                        o_push.ev    = make_event(EV_TRUNCATED, 16'd0, 16'd0,
                                                  1'b0, 8'd0, 1'b0);
                    end
                    n_bytes_left = b;
                    n_phase      = (b != 8'd0) ? PH_TYPE : PH_IDLE;
                end
                OP_CONNECT: begin
                    o_push.valid = 1'b1;
                    o_push.ev    = make_event(EV_CONNECT, 16'd0, 16'd0, 1'b0, 8'd0,
                                              r_uplink == UP_OPENED);
                    if (r_uplink != UP_OPENED) begin
                        n_uplink = UP_OPENING;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bytes_left   <= 8'd0;
            r_xor          <= 8'd0;
            r_kind         <= PK_END;
            r_field        <= 16'd0;
            r_held         <= 16'd0;
            r_payload_left <= 8'd0;
            r_uplink       <= UP_CLOSED;
            r_down_open    <= 1'b0;
            r_fetch_len    <= 8'd0;
            r_size_code    <= FETCH_CODE_RESET;
        end else begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_xor          <= n_xor;
            r_kind         <= n_kind;
            r_field        <= n_field;
            r_held         <= n_held;
            r_payload_left <= n_payload_left;
            r_uplink       <= n_uplink;
            r_down_open    <= n_down_open;
            r_fetch_len    <= n_fetch_len;
            if (i_cfg_wr_en) begin
                r_size_code <= i_cfg_wr_data;
            end
        end
    end

endmodule

[design/xcpd_queue.sv]
// ============================================================================
// Packet deframer event queue
// Small FIFO that decouples the parser from the result stage.
// ============================================================================
module xcpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xcpd_pkg::t_ev_push i_push,
    input  logic               i_pop,
    output xcpd_pkg::t_event   o_head,
    output xcpd_pkg::t_q_stat  o_stat
);
    import xcpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_event         r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           wr, rd;

    assign wr            = i_push.valid && (r_count != CW'(DEPTH));
    assign rd            = i_pop && (r_count != '0);
    assign o_head        = r_mem[r_rd_ptr];
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == CW'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr && !rd) begin
            n_count = r_count + CW'(1);
        end else if (rd && !wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_push.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[design/xcpd_back.sv]
// ============================================================================
// Packet deframer result stage
// Moves events from the queue into the output register and hands them out.
// ============================================================================
module xcpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xcpd_pkg::t_event  i_head,
    input  xcpd_pkg::t_q_stat i_stat,
    output logic              o_q_pop,
    input  logic              pop,
    output logic              empty,
    output xcpd_pkg::t_event  o_ev
);
    import xcpd_pkg::*;

    logic   r_valid, n_valid;
    t_event r_ev;
    logic   load;

    assign load    = !i_stat.empty && (!r_valid || pop);
    assign o_q_pop = load;
    assign n_valid = load || (r_valid && !pop);
    assign empty   = !r_valid;
    assign o_ev    = r_ev;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

[design/xor_checked_packet_deframer.sv]
// ============================================================================
// XOR checked packet deframer
// Parses length-prefixed blocks of checksummed packets into a stream of events.
// ============================================================================
// An event passes through the event queue and then the output register to the result ports.
// Throughput: one input beat per cycle, as the parser updates its state for every beat.
// The input stalls only while the event queue of QUEUE_DEPTH entries is full.
// Reset is synchronous and active low; it clears parser, link state and queue,
// and sets the read size code to one.
module xor_checked_packet_deframer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_event_kind,
    output logic [15:0] o_seq_number,
    output logic [15:0] o_message_size,
    output logic        o_begins_message,
    output logic [7:0]  o_value_byte,
    output logic        o_connect_refused
);
    import xcpd_pkg::*;

    t_ev_push w_push;
    t_event   w_head;
    t_q_stat  w_stat;
    t_event   w_out;
    logic     w_q_pop;
    logic     w_accept;

    assign full     = w_stat.full;
    assign w_accept = push && !w_stat.full;

    xcpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_opcode      (i_opcode),
        .i_data_byte   (i_data_byte),
        .o_push        (w_push)
    );

    xcpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    xcpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_q_pop (w_q_pop),
        .pop     (pop),
        .empty   (empty),
        .o_ev    (w_out)
    );

    assign o_event_kind      = w_out.kind;
    assign o_seq_number      = w_out.seq;
    assign o_message_size    = w_out.size;
    assign o_begins_message  = w_out.begins;
    assign o_value_byte      = w_out.value;
    assign o_connect_refused = w_out.refused;

`ifndef SYNTHESIS
    // An event is never offered to a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_stat.full)
        else $error("event produced while queue full");

    // The result register only fills from a non-empty queue.
    a_load_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.empty && (empty || pop)) |=> empty)
        else $error("result appeared without a queued event");

    // A held result carries a defined event code.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_event_kind <= EV_CONNECT))
        else $error("result carries an undefined event code");
`endif

endmodule

[tb/xor_checked_packet_deframer_tb.sv]
// ============================================================================
// XOR checked packet deframer testbench
// Drives length-prefixed blocks of checksummed packets, connect requests and
// stray beats into the deframer. A parser model inside the testbench predicts
// the event stream, and every popped event is compared field by field. Random
// sender bursts, receiver stalls, one long receiver hold-off and several read
// size codes are applied.
// ============================================================================
module xor_checked_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcpd_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;

    localparam int BLK_EXACT  = 0;
    localparam int BLK_SHORT  = 1;
    localparam int BLK_BROKEN = 2;
    localparam int BLK_LONG   = 3;

    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;

    typedef struct packed {
        t_opcode    op;
        logic [7:0] data;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_opcode = OP_NONE;
    logic [7:0]  i_data_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_event_kind;
    logic [15:0] o_seq_number;
    logic [15:0] o_message_size;
    logic        o_begins_message;
    logic [7:0]  o_value_byte;
    logic        o_connect_refused;

    xor_checked_packet_deframer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .push              (push),
        .full              (full),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .empty             (empty),
        .pop               (pop),
        .o_event_kind      (o_event_kind),
        .o_seq_number      (o_seq_number),
        .o_message_size    (o_message_size),
        .o_begins_message  (o_begins_message),
        .o_value_byte      (o_value_byte),
        .o_connect_refused (o_connect_refused)
    );

    always #5 i_clk = ~i_clk;

    t_beat      pending_beats[$];
    t_event     expected_events[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         beat_taken = 1'b0;
    bit         hold_request = 1'b0;

    // Parser model state.
    t_phase     ph;
    t_uplink    up_state;
    logic [7:0] blk_left;
    logic [7:0] xsum;
    logic [2:0] pkind;
    logic [15:0] field_word;
    logic [15:0] size_word;
    logic [7:0] pay_left;
    logic       dl_open;
    logic [7:0] fetch_len;
    logic [7:0] code_sel;

    // Stimulus state.
    logic [7:0] blk_bytes[$];
    logic [7:0] cur_code = FETCH_CODE_RESET;
    int         fill_byte = -1;
    int         gen_count;

    task automatic reset_model();
        ph         = PH_IDLE;
        up_state   = UP_CLOSED;
        blk_left   = 8'd0;
        xsum       = 8'd0;
        pkind      = PK_END;
        field_word = 16'd0;
        size_word  = 16'd0;
        pay_left   = 8'd0;
        dl_open    = 1'b0;
        fetch_len  = 8'd0;
        code_sel   = FETCH_CODE_RESET;
    endtask

    function automatic t_event ev_plain(input logic [3:0] kind);
        t_event e;
        e = '0;
        e.kind = kind;
        return e;
    endfunction

    function automatic t_event ev_msg(input logic [3:0] kind, input logic [7:0] val);
        t_event e;
        e = ev_plain(kind);
        e.seq = field_word;
        e.begins = (pkind == PK_BEGIN);
        e.size = e.begins ? size_word : 16'd0;
        e.value = val;
        return e;
    endfunction

    task automatic deframe_data_byte(input logic [7:0] b);
        t_event ev;
        logic   has_ev;
        has_ev = 1'b0;
        ev = '0;
        blk_left = blk_left - 8'd1;
        if (ph != PH_TYPE && ph != PH_CHECK) xsum = xsum ^ b;
        case (ph)
            PH_TYPE: begin
                if (b == 8'd0) begin
                    ph = PH_IDLE;
                    blk_left = 8'd0;
                end else if (b > 8'd7 || b[2:0] == PK_CLOSE || b[2:0] == PK_REQ_UP) begin
                    ev = ev_plain(EV_UNSUPPORTED);
                    has_ev = 1'b1;
                    ph = PH_IDLE;
                    blk_left = 8'd0;
                end else begin
                    pkind = b[2:0];
                    xsum = b;
                    field_word = 16'd0;
                    size_word = 16'd0;
                    pay_left = 8'd0;
                    case (b[2:0])
                        PK_OPEN:     ph = PH_CHECK;
                        PK_BEGIN:    ph = PH_SIZE_LO;
                        PK_SET_PARM: ph = PH_PCODE;
                        default:     ph = PH_SEQ_LO;
                    endcase
                end
            end
            PH_SIZE_LO: begin
                size_word = {8'd0, b};
                ph = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
                size_word[15:8] = b;
                ph = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                field_word = {8'd0, b};
                ph = PH_SEQ_HI;
            end
            PH_SEQ_HI: begin
                field_word[15:8] = b;
                ph = (pkind == PK_ACK) ? PH_CHECK : PH_PLEN;
            end
            PH_PLEN: begin
                pay_left = b;
                ev = ev_msg(EV_MSG_HEADER, b);
                has_ev = 1'b1;
                ph = (b != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
                ev = ev_msg(EV_PAYLOAD, b);
                has_ev = 1'b1;
                pay_left = pay_left - 8'd1;
                if (pay_left == 8'd0) ph = PH_CHECK;
            end
            PH_PCODE: begin
                ph = (b == code_sel) ? PH_PVAL : PH_TYPE;
            end
            PH_PVAL: begin
                field_word = {8'd0, b};
                ph = PH_CHECK;
            end
            default: begin
                has_ev = 1'b1;
                if (b != xsum) begin
                    ev = ev_plain(EV_CHECK_ERR);
                    ph = PH_IDLE;
                    blk_left = 8'd0;
                end else begin
                    case (pkind)
                        PK_OPEN: begin
                            dl_open = 1'b1;
                            ev = ev_plain(EV_OPEN);
                        end
                        PK_ACK: begin
                            ev = ev_plain(EV_DATA_ACK);
                            if (up_state == UP_OPENING) begin
                                up_state = UP_OPENED;
                                ev.kind = EV_UP_OPENED;
                            end else if (up_state == UP_CLOSING) begin
                                up_state = UP_CLOSED;
                                ev.kind = EV_UP_CLOSED;
                            end
                            ev.seq = field_word;
                        end
                        PK_SET_PARM: begin
                            fetch_len = field_word[7:0];
                            ev = ev_plain(EV_FETCH_LEN);
                            ev.value = fetch_len;
                        end
                        default: begin
                            ev = ev_msg(EV_MSG_DONE, 8'd0);
                        end
                    endcase
                    ph = PH_TYPE;
                end
            end
        endcase
        // A block that ends inside a packet reports truncation instead.
        if (blk_left == 8'd0 && ph != PH_IDLE) begin
            if (ph != PH_TYPE) begin
                ev = ev_plain(EV_TRUNCATED);
                has_ev = 1'b1;
            end
            ph = PH_IDLE;
        end
        if (has_ev) expected_events.push_back(ev);
    endtask

    task automatic deframe_beat(input t_opcode op, input logic [7:0] b);
        t_event ev;
        case (op)
            OP_DATA: begin
                if (ph != PH_IDLE) deframe_data_byte(b);
            end
            OP_START: begin
                if (ph != PH_IDLE && ph != PH_TYPE)
                    expected_events.push_back(ev_plain(EV_TRUNCATED));
                blk_left = b;
                ph = (b != 8'd0) ? PH_TYPE : PH_IDLE;
            end
            OP_CONNECT: begin
                ev = ev_plain(EV_CONNECT);
                if (up_state == UP_OPENED) ev.refused = 1'b1;
                else up_state = UP_OPENING;
                expected_events.push_back(ev);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_event want;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_wr_en) code_sel = i_cfg_wr_data;
            if (push && !full) begin
                beat_taken = 1'b1;
                deframe_beat(t_opcode'(i_opcode), i_data_byte);
            end
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    $error("event_kind: expected no event, got %0h", o_event_kind);
                    fail_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 16'(want.kind), 16'(o_event_kind));
                    check_field("seq_number", want.seq, o_seq_number);
                    check_field("message_size", want.size, o_message_size);
                    check_field("begins_message", 16'(want.begins),
                                16'(o_begins_message));
                    check_field("value_byte", 16'(want.value), 16'(o_value_byte));
                    check_field("connect_refused", 16'(want.refused),
                                16'(o_connect_refused));
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_beat nxt;
        int    burst_left;
        int    gap_left;
        if (!i_rst_n) begin
            push <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!push || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                nxt = pending_beats.pop_front();
                push <= 1'b1;
                i_opcode <= nxt.op;
                i_data_byte <= nxt.data;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        int hold_left;
        int rx_left;
        int rx_mode;
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_left = 0;
            rx_left = 0;
            rx_mode = RX_FREE;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_SPARSE);
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE: pop <= 1'b1;
                    RX_HALF: pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic queue_beat(input t_opcode op, input logic [7:0] data);
        t_beat bt;
        bt.op = op;
        bt.data = data;
        pending_beats.push_back(bt);
    endtask

    function automatic logic [7:0] field_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (fill_byte >= 0) v = fill_byte[7:0];
        return v;
    endfunction

    task automatic add_packet(input logic [7:0] ptype, input bit bad, input int plen_req);
        int         start;
        int         plen;
        logic [7:0] x;
        logic [7:0] pcode;
        start = blk_bytes.size();
        blk_bytes.push_back(ptype);
        case (ptype)
            PK_OPEN: ;
            PK_ACK: begin
                blk_bytes.push_back(field_byte());
                blk_bytes.push_back(field_byte());
            end
            PK_BEGIN, PK_CONTINUE: begin
                repeat ((ptype == PK_BEGIN) ? 4 : 2) blk_bytes.push_back(field_byte());
                if (plen_req >= 0) plen = plen_req;
                else if ($urandom_range(0, 9) == 0) plen = $urandom_range(7, 20);
                else plen = $urandom_range(0, 6);
                blk_bytes.push_back(plen[7:0]);
                repeat (plen) blk_bytes.push_back(8'($urandom_range(0, 255)));
            end
            PK_SET_PARM: begin
                pcode = cur_code;
                if (fill_byte < 0 && $urandom_range(0, 3) == 0)
                    pcode = 8'($urandom_range(0, 255));
                blk_bytes.push_back(pcode);
                if (pcode != cur_code) return;
                blk_bytes.push_back(field_byte());
            end
            default: return;
        endcase
        x = 8'd0;
        for (int i = start; i < blk_bytes.size(); i++) x = x ^ blk_bytes[i];
        if (bad) x = x ^ 8'($urandom_range(1, 255));
        blk_bytes.push_back(x);
    endtask

    task automatic send_block(input int mode);
        int total;
        int len;
        int sent;
        total = blk_bytes.size();
        len = total;
        sent = total;
        if (mode == BLK_SHORT && total > 1) len = $urandom_range(1, total - 1);
        else if (mode == BLK_BROKEN && total > 1) sent = $urandom_range(1, total - 1);
        else if (mode == BLK_LONG) len = (total + 3 > 255) ? 255 : total + $urandom_range(1, 3);
        queue_beat(OP_START, len[7:0]);
        for (int i = 0; i < sent; i++) begin
            if (fill_byte < 0 && $urandom_range(0, 39) == 0)
                queue_beat(OP_CONNECT, 8'($urandom_range(0, 255)));
            if (fill_byte < 0 && $urandom_range(0, 79) == 0)
                queue_beat(OP_NONE, 8'($urandom_range(0, 255)));
            queue_beat(OP_DATA, blk_bytes[i]);
        end
        gen_count += sent + 1;
        blk_bytes.delete();
    endtask

    task automatic random_block();
        int         r;
        bit         bad;
        logic [7:0] t;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 99);
            bad = ($urandom_range(0, 19) == 0);
            if (r < 14) begin
                t = 8'(PK_OPEN);
            end else if (r < 30) begin
                t = 8'(PK_ACK);
            end else if (r < 52) begin
                t = 8'(PK_BEGIN);
            end else if (r < 72) begin
                t = 8'(PK_CONTINUE);
            end else if (r < 84) begin
                t = 8'(PK_SET_PARM);
            end else if (r < 92) begin
                if ($urandom_range(0, 2) != 0) t = 8'($urandom_range(8, 255));
                else t = ($urandom_range(0, 1) != 0) ? 8'(PK_CLOSE) : 8'(PK_REQ_UP);
            end else begin
                t = 8'(PK_END);
            end
            add_packet(t, bad, -1);
        end
        r = $urandom_range(0, 99);
        if (r < 76) send_block(BLK_EXACT);
        else if (r < 86) send_block(BLK_SHORT);
        else if (r < 96) send_block(BLK_BROKEN);
        else send_block(BLK_LONG);
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || push || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_code(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        cur_code = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n_beats);
        gen_count = 0;
        while (gen_count < n_beats) random_block();
        // An empty block leaves the parser idle before the next setting.
        queue_beat(OP_START, 8'd0);
        wait_idle();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("xor_checked_packet_deframer_tb failed");
        $finish;
    end

    initial begin
        reset_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(OP_DATA, 8'hFF);
        queue_beat(OP_NONE, 8'h5A);
        queue_beat(OP_CONNECT, 8'h00);
        queue_beat(OP_START, 8'h00);
        fill_byte = 255;
        add_packet(8'(PK_OPEN), 1'b0, -1);
        add_packet(8'(PK_ACK), 1'b0, -1);
        add_packet(8'(PK_SET_PARM), 1'b0, -1);
        add_packet(8'(PK_END), 1'b0, -1);
        send_block(BLK_EXACT);
        queue_beat(OP_CONNECT, 8'hFF);
        add_packet(8'(PK_BEGIN), 1'b0, 0);
        send_block(BLK_EXACT);
        fill_byte = -1;
        wait_idle();

        write_code(8'd0);
        run_phase(50);

        write_code(8'd255);
        hold_request = 1'b1;
        add_packet(8'(PK_BEGIN), 1'b0, 248);
        send_block(BLK_EXACT);
        run_phase(50);

        write_code(8'($urandom_range(0, 255)));
        run_phase(50);

        write_code(FETCH_CODE_RESET);
        run_phase(70);

        if (fail_count == 0) begin
            $display("xor_checked_packet_deframer_tb passed");
        end else begin
            $display("xor_checked_packet_deframer_tb failed");
        end
        $finish;
    end

endmodule
